### hw/rtl/mbss_pkg.sv
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types, register indexes and match-kind codes for the masked byte
// signature scanner.
// ----------------------------------------------------------------------------
package mbss_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_PATTERN_LOW    = 3'd0;
   localparam logic [2:0] REG_PATTERN_HIGH   = 3'd1;
   localparam logic [2:0] REG_WILDCARD_MASK  = 3'd2;
   localparam logic [2:0] REG_PATTERN_LENGTH = 3'd3;
   localparam logic [2:0] REG_MATCH_KIND     = 3'd4;
   localparam logic [2:0] REG_REPORT_ALL     = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // match kinds
   localparam logic [1:0] KIND_SIGNATURE = 2'd0;
   localparam logic [1:0] KIND_EXACT     = 2'd1;
   localparam logic [1:0] KIND_CASELESS  = 2'd2;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int OFFSET_OUT_W = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef struct packed {
      logic                    matched;
      logic [OFFSET_OUT_W-1:0] match_offset;
      logic [2:0]              confidence_quarters;
      logic                    buffer_done;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type word;
   } push_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

### hw/rtl/mbss_front.sv
// ----------------------------------------------------------------------------
// mbss_front
// Configuration registers, byte window, byte count and parallel window
// compare. Produces one result word per reported match or buffer end.
// ----------------------------------------------------------------------------
module mbss_front #(
   parameter int PATTERN_BYTES = 16,
   parameter int OFFSET_BITS   = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mbss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbss_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               accept,
   input  logic [7:0]                         data_byte,
   input  logic                               last_in_buffer,
   output mbss_pkg::push_type                 push
);

   localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam logic [4:0] DEPTH_LEN = 5'(PATTERN_BYTES);
   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic [15:0] wildcard_mask_ff;
   logic [4:0]  pattern_length_ff;
   logic [1:0]  match_kind_ff;
   logic        report_all_ff;

   logic [7:0]             window_ff [PATTERN_BYTES];
   logic [7:0]             window_in [PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] seen_ff;
   logic [OFFSET_BITS-1:0] seen_in;
   logic                   found_ff;

   logic [4:0]              len;
   logic                    all_equal;
   logic                    all_wild;
   logic                    hit;
   logic                    report;
   logic [2:0]              conf;
   logic [OFFSET_BITS-1:0]  off_full;
   logic [63:0]             off_wide;
   logic [mbss_pkg::OFFSET_OUT_W-1:0] off_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= 5'd1;
         match_kind_ff     <= mbss_pkg::KIND_SIGNATURE;
         report_all_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mbss_pkg::REG_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            mbss_pkg::REG_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            mbss_pkg::REG_WILDCARD_MASK:  wildcard_mask_ff  <= csr_wdata[15:0];
            mbss_pkg::REG_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[4:0];
            mbss_pkg::REG_MATCH_KIND:     match_kind_ff     <= csr_wdata[1:0];
            mbss_pkg::REG_REPORT_ALL:     report_all_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [127:0] pattern;
      logic [4:0]   idx;
      logic [7:0]   d;
      logic [7:0]   p;

      pattern = {pattern_high_ff, pattern_low_ff};
      len = (pattern_length_ff > DEPTH_LEN) ? DEPTH_LEN : pattern_length_ff;

      window_in[0] = data_byte;
      for (int k = 1; k < PATTERN_BYTES; k++) begin
         window_in[k] = window_ff[k-1];
      end
      seen_in = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + 1'b1;

      all_equal = 1'b1;
      all_wild  = 1'b1;
      idx = '0;
      d   = '0;
      p   = '0;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         if (5'(j) < len) begin
            idx = len - 5'd1 - 5'(j);
            d   = window_in[idx[IDX_W-1:0]];
            p   = pattern[8*j +: 8];
            case (match_kind_ff)
               mbss_pkg::KIND_SIGNATURE: begin
                  all_wild = all_wild & wildcard_mask_ff[j];
                  if (!wildcard_mask_ff[j] && d != p) begin
                     all_equal = 1'b0;
                  end
               end
               mbss_pkg::KIND_CASELESS: begin
                  if (mbss_pkg::fold_case(d) != mbss_pkg::fold_case(p)) begin
                     all_equal = 1'b0;
                  end
               end
               default: begin
                  // exact string, also for the unused code
                  if (d != p) begin
                     all_equal = 1'b0;
                  end
               end
            endcase
         end
      end

      hit = (len != 5'd0) && (seen_in >= OFFSET_BITS'(len)) && all_equal;

      if (match_kind_ff == mbss_pkg::KIND_SIGNATURE) begin
         conf = all_wild ? 3'd2 : ((len < 5'd4) ? len[2:0] : 3'd4);
      end else begin
         conf = 3'd4;
      end

      report = hit && ((match_kind_ff == mbss_pkg::KIND_SIGNATURE && report_all_ff)
                       || !found_ff);

      off_full = (seen_in == COUNT_MAX) ? seen_in : seen_in - OFFSET_BITS'(len);
      off_wide = 64'(off_full);
      off_out  = (|off_wide[63:32]) ? '1 : off_wide[31:0];

      push.valid                    = accept && (report || last_in_buffer);
      push.word.matched             = report;
      push.word.match_offset        = report ? off_out : '0;
      push.word.confidence_quarters = report ? conf : 3'd0;
      push.word.buffer_done         = last_in_buffer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_BYTES; k++) begin
            window_ff[k] <= '0;
         end
         seen_ff  <= '0;
         found_ff <= 1'b0;
      end else if (accept) begin
         if (last_in_buffer) begin
            for (int k = 0; k < PATTERN_BYTES; k++) begin
               window_ff[k] <= '0;
            end
            seen_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            window_ff <= window_in;
            seen_ff   <= seen_in;
            found_ff  <= found_ff | hit;
         end
      end
   end

endmodule

### hw/rtl/mbss_queue.sv
// ----------------------------------------------------------------------------
// mbss_queue
// Small result word queue between the scan front and the output stage.
// ----------------------------------------------------------------------------
module mbss_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  mbss_pkg::push_type   push,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output mbss_pkg::result_type head
);

   mbss_pkg::result_type mem_ff [mbss_pkg::QUEUE_DEPTH];
   logic [mbss_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [mbss_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [mbss_pkg::QUEUE_PTR_W:0]   count_ff;
   logic                             do_push;
   logic                             do_pop;

   assign full    = (count_ff == (mbss_pkg::QUEUE_PTR_W+1)'(mbss_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

endmodule

### hw/rtl/mbss_back.sv
// ----------------------------------------------------------------------------
// mbss_back
// Output register stage: takes words from the queue and drives the result
// stream.
// ----------------------------------------------------------------------------
module mbss_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  mbss_pkg::result_type                head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mbss_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   logic                 out_valid_ff;
   mbss_pkg::result_type out_word_ff;

   assign pop = head_valid && (!out_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_word_ff <= head;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_word_ff.confidence_quarters, out_word_ff.match_offset};
   assign rsp_tuser  = out_word_ff.matched;
   assign rsp_tlast  = out_word_ff.buffer_done;

endmodule

### hw/rtl/masked_byte_signature_scanner_unit.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner_unit
// Scans a byte stream for a masked signature or a string of up to
// PATTERN_BYTES bytes and reports match offsets per buffer.
// ----------------------------------------------------------------------------
// One byte is taken every cycle; all window positions are compared in
// parallel in the same cycle the byte arrives. A word is produced for each
// reported match and for the last byte of every buffer; it passes through the
// queue and the output register. A four-word queue sits between the scanner
// and the output register, so the input keeps flowing while the result side
// is briefly stalled; input ready drops only when that queue is full. The
// user must make configuration writes only while idle; this is not enforced.
module masked_byte_signature_scanner_unit #(
   parameter int PATTERN_BYTES = 16,
   parameter int OFFSET_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mbss_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [7:0] data_byte
   input  logic                                req_tlast,  // last_in_buffer
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mbss_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [31:0] match_offset,
                                                           // [34:32] confidence_quarters
   output logic                                rsp_tuser,  // matched
   output logic                                rsp_tlast,  // buffer_done
   input  logic                                csr_we,
   input  logic [mbss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbss_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                 accept;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 pop;
   mbss_pkg::push_type   push;
   mbss_pkg::result_type head;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   mbss_front #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .accept         (accept),
      .data_byte      (req_tdata[7:0]),
      .last_in_buffer (req_tlast),
      .push           (push)
   );

   mbss_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (head)
   );

   mbss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!queue_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/mbss_checker.sv
// ----------------------------------------------------------------------------
// mbss_checker
// Port-level checks on the scanner result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mbss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mbss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_nomatch_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("word without match is not a buffer end");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("offset or confidence set without match");

   a_match_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[34:32] != 3'd0 && rsp_tdata[34:32] <= 3'd4
         && rsp_tdata[39:35] == 5'd0)
      else $error("confidence out of range on match");

endmodule

bind masked_byte_signature_scanner_unit mbss_checker u_mbss_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
